/* rtl/pcd_pkg.sv */
package pcd_pkg;

    // Byte role codes reported with every result.
    localparam logic [2:0] ROLE_SIG  = 3'd0;
    localparam logic [2:0] ROLE_LEN  = 3'd1;
    localparam logic [2:0] ROLE_TYPE = 3'd2;
    localparam logic [2:0] ROLE_DATA = 3'd3;
    localparam logic [2:0] ROLE_CRC  = 3'd4;
    localparam logic [2:0] ROLE_END  = 3'd5;

    // Field widths.
    localparam int LEN_W  = 31;
    localparam int WORD_W = 32;
    localparam int IDX_W  = 3;

    // Saturated length and the chunk type that closes a file ("IEND").
    localparam logic [LEN_W-1:0]  LEN_MAX  = 31'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] END_TYPE = {8'h49, 8'h45, 8'h4E, 8'h44};

    // Reset value of the zero-type-ends register.
    localparam logic ZERO_TYPE_ENDS_RST = 1'b1;

    // Parser phase, one-hot.
    typedef enum logic [5:0] {
        PH_SIG  = 6'b000001,
        PH_LEN  = 6'b000010,
        PH_TYPE = 6'b000100,
        PH_DATA = 6'b001000,
        PH_CRC  = 6'b010000,
        PH_END  = 6'b100000
    } t_phase;

    // One result as it leaves the parser step.
    typedef struct packed {
        logic [2:0]        byte_role;
        logic [7:0]        data_byte;
        logic [LEN_W-1:0]  chunk_length;
        logic [WORD_W-1:0] chunk_type;
        logic [WORD_W-1:0] crc_word;
        logic              chunk_done;
        logic              end_found;
        logic              length_over;
    } t_result;

endpackage

/* rtl/pcd_step.sv */
module pcd_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [7:0]        i_file_byte,
    input  logic              i_stream_start,
    input  logic              i_zero_type_ends,
    output pcd_pkg::t_result  o_result
);

    pcd_pkg::t_phase                 r_phase, n_phase, s_phase;
    logic [pcd_pkg::IDX_W-1:0]       r_idx, n_idx, s_idx, inc_idx;
    logic [pcd_pkg::LEN_W-1:0]       r_left, n_left, s_left;
    logic [pcd_pkg::LEN_W-1:0]       r_len, n_len, s_len;
    logic [pcd_pkg::WORD_W-1:0]      r_type, n_type, s_type;
    logic [pcd_pkg::WORD_W-1:0]      r_crc, n_crc, s_crc;
    logic                            r_ended, n_ended, s_ended;
    logic                            r_over, n_over, s_over;
    logic [2:0]                      role;
    logic                            done;

    // A stream start restarts the parse before the byte is handled.
    always_comb begin
        s_phase = i_stream_start ? pcd_pkg::PH_SIG : r_phase;
        s_idx   = i_stream_start ? '0 : r_idx;
        s_left  = i_stream_start ? '0 : r_left;
        s_len   = i_stream_start ? '0 : r_len;
        s_type  = i_stream_start ? '0 : r_type;
        s_crc   = i_stream_start ? '0 : r_crc;
        s_ended = i_stream_start ? 1'b0 : r_ended;
        s_over  = i_stream_start ? 1'b0 : r_over;
    end

    assign inc_idx = s_idx + 3'd1;

    // Next parse state for one byte.
    always_comb begin
        n_phase = s_phase;
        n_idx   = s_idx;
        n_left  = s_left;
        n_len   = s_len;
        n_type  = s_type;
        n_crc   = s_crc;
        n_ended = s_ended;
        n_over  = s_over;
        role    = pcd_pkg::ROLE_END;
        done    = 1'b0;
        case (s_phase)
            pcd_pkg::PH_SIG: begin
                role  = pcd_pkg::ROLE_SIG;
                n_idx = inc_idx;
                if (inc_idx == '0) begin
                    n_phase = pcd_pkg::PH_LEN;
                end
            end
            pcd_pkg::PH_LEN: begin
                role = pcd_pkg::ROLE_LEN;
                // The first length byte opens a new chunk.
                if (s_idx == '0) begin
                    n_len  = {23'd0, i_file_byte};
                    n_type = '0;
                    n_crc  = '0;
                    n_over = i_file_byte[7];
                end else begin
                    n_len  = {s_len[pcd_pkg::LEN_W-9:0], i_file_byte};
                end
                n_idx = inc_idx;
                if (inc_idx[2]) begin
                    n_idx   = '0;
                    n_left  = n_over ? pcd_pkg::LEN_MAX : n_len;
                    n_phase = pcd_pkg::PH_TYPE;
                end
            end
            pcd_pkg::PH_TYPE: begin
                role   = pcd_pkg::ROLE_TYPE;
                n_type = {s_type[pcd_pkg::WORD_W-9:0], i_file_byte};
                n_idx  = inc_idx;
                if (inc_idx[2]) begin
                    n_idx = '0;
                    if ((n_type == pcd_pkg::END_TYPE)
                            || (i_zero_type_ends && (n_type == '0))) begin
                        n_ended = 1'b1;
                        n_phase = pcd_pkg::PH_END;
                    end else if (s_left == '0) begin
                        n_phase = pcd_pkg::PH_CRC;
                    end else begin
                        n_phase = pcd_pkg::PH_DATA;
                    end
                end
            end
            pcd_pkg::PH_DATA: begin
                role = pcd_pkg::ROLE_DATA;
                if (s_left != '0) begin
                    n_left = s_left - 31'd1;
                end
                if (n_left == '0) begin
                    n_phase = pcd_pkg::PH_CRC;
                end
            end
            pcd_pkg::PH_CRC: begin
                role  = pcd_pkg::ROLE_CRC;
                n_crc = {s_crc[pcd_pkg::WORD_W-9:0], i_file_byte};
                n_idx = inc_idx;
                if (inc_idx[2]) begin
                    n_idx   = '0;
                    done    = 1'b1;
                    n_phase = pcd_pkg::PH_LEN;
                end
            end
            default: begin
                // After the end, and any code that should never occur.
                role    = pcd_pkg::ROLE_END;
                n_phase = pcd_pkg::PH_END;
            end
        endcase
    end

    // Result fields come from the updated state.
    always_comb begin
        o_result.byte_role    = role;
        o_result.data_byte    = i_file_byte;
        o_result.chunk_length = n_over ? pcd_pkg::LEN_MAX : n_len;
        o_result.chunk_type   = n_type;
        o_result.crc_word     = n_crc;
        o_result.chunk_done   = done;
        o_result.end_found    = n_ended;
        o_result.length_over  = n_over;
    end

    // Parse state advances on each byte handed in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pcd_pkg::PH_SIG;
            r_idx   <= '0;
            r_left  <= '0;
            r_len   <= '0;
            r_type  <= '0;
            r_crc   <= '0;
            r_ended <= 1'b0;
            r_over  <= 1'b0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_left  <= n_left;
            r_len   <= n_len;
            r_type  <= n_type;
            r_crc   <= n_crc;
            r_ended <= n_ended;
            r_over  <= n_over;
        end
    end

endmodule

/* rtl/png_chunk_deframer_core.sv */
// Channel   Direction  Handshake            Payload
// in        input      i_valid / o_ready    i_file_byte, i_stream_start
// out       output     o_valid / i_ready    o_byte_role .. o_length_over
// cfg       input      i_cfg_we             i_cfg_wdata (zero-type-ends flag)
//
// One byte is taken per clock while the output is not stalled; each accepted request
// passes the input register, then the parser step into the result register.
// The parse state and the result register advance together in the same cycle.
// Reset is synchronous and active low; it clears the parse state and sets
// the zero-type-ends flag. When the output stalls, the input register still
// holds one more request before o_ready drops.
module png_chunk_deframer_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Input requests
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [7:0]                  i_file_byte,
    input  logic                        i_stream_start,
    // Configuration
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_wdata,
    // Results
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [2:0]                  o_byte_role,
    output logic [7:0]                  o_data_byte,
    output logic [pcd_pkg::LEN_W-1:0]   o_chunk_length,
    output logic [pcd_pkg::WORD_W-1:0]  o_chunk_type,
    output logic [pcd_pkg::WORD_W-1:0]  o_crc_word,
    output logic                        o_chunk_done,
    output logic                        o_end_found,
    output logic                        o_length_over
);

    logic              r_zero_ends;
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_start;
    logic              r_out_valid;
    pcd_pkg::t_result  r_out;
    pcd_pkg::t_result  step_result;
    logic              advance;

    // The step fires when the result register is free or being emptied.
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_ends <= pcd_pkg::ZERO_TYPE_ENDS_RST;
        end else if (i_cfg_we) begin
            r_zero_ends <= i_cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte  <= i_file_byte;
            r_in_start <= i_stream_start;
        end
    end

    pcd_step u_step (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (advance),
        .i_file_byte      (r_in_byte),
        .i_stream_start   (r_in_start),
        .i_zero_type_ends (r_zero_ends),
        .o_result         (step_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_byte_role    = r_out.byte_role;
    assign o_data_byte    = r_out.data_byte;
    assign o_chunk_length = r_out.chunk_length;
    assign o_chunk_type   = r_out.chunk_type;
    assign o_crc_word     = r_out.crc_word;
    assign o_chunk_done   = r_out.chunk_done;
    assign o_end_found    = r_out.end_found;
    assign o_length_over  = r_out.length_over;

endmodule
